@@ rtl/rtpf_pkg.sv @@
// rtpf_pkg: shared types and constants of the row trace peak finder
// used by the interfaces, the tracker, the result queue and the top level
`timescale 1ns / 1ps
`default_nettype none

package rtpf_pkg;

   localparam int VALUE_W   = 32;
   localparam int MASK_W    = 32;
   localparam int SPAN_W    = 12;
   localparam int ROW_IDX_W = 13;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BAD_BIT_MASK = 1'd1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_RISING  = 2'd1,
      MODE_FALLING = 2'd2
   } mode_type;

   typedef struct packed {
      logic [ROW_IDX_W-1:0] row_index;
      logic [SPAN_W-1:0]    span_start;
      logic [SPAN_W-1:0]    peak_column;
      logic [SPAN_W-1:0]    span_end;
      logic                 last_of_run;
   } result_type;

   typedef struct packed {
      logic       first_valid;
      logic       second_valid;
      result_type first;
      result_type second;
   } push_type;

endpackage

`default_nettype wire

@@ rtl/rtpf_if.sv @@
// rtpf_req_if / rtpf_rsp_if: valid-ready channels for pixel items and span items
// depends on rtpf_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rtpf_req_if
   import rtpf_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] pixel_value;
   logic [MASK_W-1:0]         pixel_mask;
   logic                      row_end;
   logic                      frame_start;

   modport source (output valid, pixel_value, pixel_mask, row_end, frame_start,
                   input ready);
   modport sink   (input valid, pixel_value, pixel_mask, row_end, frame_start,
                   output ready);
endinterface

interface rtpf_rsp_if
   import rtpf_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [ROW_IDX_W-1:0] row_index;
   logic [SPAN_W-1:0]    span_start;
   logic [SPAN_W-1:0]    peak_column;
   logic [SPAN_W-1:0]    span_end;
   logic                 last_of_run;

   modport source (output valid, row_index, span_start, peak_column, span_end,
                   last_of_run, input ready);
   modport sink   (input valid, row_index, span_start, peak_column, span_end,
                   last_of_run, output ready);
endinterface

`default_nettype wire

@@ rtl/row_trace_peak_finder.sv @@
// row_trace_peak_finder: top level, threshold segmentation of image rows into spans
// depends on rtpf_pkg, rtpf_if, rtpf_tracker and rtpf_out_queue
//
//   channel  direction  carries
//   req_ch   in         pixel_value, pixel_mask, row_end, frame_start
//   rsp_ch   out        row_index, span_start, peak_column, span_end, last_of_run
//   csr_*    in         write of threshold (index 0) or bad_bit_mask (index 1)
//
// one pixel a cycle unless stalled; a pixel's items pass the input register and queue
// a pixel that ends a row can give two items, which drain one a cycle from the queue while rsp_ch is ready
// pixels stall while the four-entry span queue has fewer than two free entries
// synchronous reset clears the mode, counters and queue; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module row_trace_peak_finder
   import rtpf_pkg::*;
#(
   parameter int MAX_COLUMNS = 4096,
   parameter int MAX_ROWS    = 8192
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   rtpf_req_if.sink                  req_ch,
   rtpf_rsp_if.source                rsp_ch,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [VALUE_W-1:0]   csr_wr_data
);

   push_type push;
   logic     space_ok;

   rtpf_tracker #(
      .MAX_COLUMNS(MAX_COLUMNS),
      .MAX_ROWS   (MAX_ROWS)
   ) u_tracker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data),
      .space_ok   (space_ok),
      .push       (push)
   );

   rtpf_out_queue u_out_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .space_ok(space_ok),
      .rsp     (rsp_ch)
   );

endmodule

`default_nettype wire

@@ rtl/rtpf_tracker.sv @@
// rtpf_tracker: input register, config registers and the row tracking mode logic
// produces up to two span items per pixel; depends on rtpf_pkg and rtpf_req_if
`timescale 1ns / 1ps
`default_nettype none

module rtpf_tracker
   import rtpf_pkg::*;
#(
   parameter int MAX_COLUMNS = 4096,
   parameter int MAX_ROWS    = 8192
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   rtpf_req_if.sink                  req,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [VALUE_W-1:0]   csr_wr_data,
   input  wire logic                 space_ok,
   output push_type                  push
);

   localparam int COL_W  = $clog2(MAX_COLUMNS);
   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_XW = (COL_W > SPAN_W) ? COL_W : SPAN_W;
   localparam int ROW_XW = (ROW_W > ROW_IDX_W) ? ROW_W : ROW_IDX_W;
   localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_COLUMNS - 1);
   localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(MAX_ROWS - 1);

   function automatic logic [SPAN_W-1:0] to_span(input logic [COL_W-1:0] v);
      logic [COL_XW-1:0] w;
      w = COL_XW'(v);
      return w[SPAN_W-1:0];
   endfunction

   function automatic logic [ROW_IDX_W-1:0] to_row(input logic [ROW_W-1:0] v);
      logic [ROW_XW-1:0] w;
      w = ROW_XW'(v);
      return w[ROW_IDX_W-1:0];
   endfunction

   // config registers
   logic signed [VALUE_W-1:0] threshold_ff;
   logic [MASK_W-1:0]         bad_mask_ff;

   // input register
   logic                      in_v_ff;
   logic signed [VALUE_W-1:0] in_value_ff;
   logic [MASK_W-1:0]         in_mask_ff;
   logic                      in_row_end_ff;
   logic                      in_frame_start_ff;

   // tracking state
   mode_type                  mode_ff, mode_in;
   logic [COL_W-1:0]          open_start_ff, open_start_in;
   logic [COL_W-1:0]          open_peak_ff, open_peak_in;
   logic signed [VALUE_W-1:0] prev_value_ff, prev_value_in;
   logic [COL_W-1:0]          prev_col_ff, prev_col_in;
   logic [COL_W-1:0]          col_ff, col_in;
   logic [ROW_W-1:0]          row_ff, row_in;

   logic                      take;
   mode_type                  eff_mode, mid_mode;
   logic signed [VALUE_W-1:0] eff_prev_value;
   logic [COL_W-1:0]          eff_prev_col, x;
   logic [ROW_W-1:0]          eff_row;
   logic [COL_W-1:0]          mid_start, mid_peak;
   logic                      good, above, higher, lower;
   logic                      ea_v, eb_v;
   result_type                ea, eb;

   assign take      = in_v_ff && space_ok;
   assign req.ready = !in_v_ff || take;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         bad_mask_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_THRESHOLD:    threshold_ff <= csr_wr_data;
            CSR_BAD_BIT_MASK: bad_mask_ff  <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (req.ready) begin
         in_v_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_value_ff       <= req.pixel_value;
         in_mask_ff        <= req.pixel_mask;
         in_row_end_ff     <= req.row_end;
         in_frame_start_ff <= req.frame_start;
      end
   end

   // frame start clears the row state before the pixel is looked at
   always_comb begin
      eff_mode       = in_frame_start_ff ? MODE_IDLE : mode_ff;
      eff_prev_value = in_frame_start_ff ? '0 : prev_value_ff;
      eff_prev_col   = in_frame_start_ff ? '0 : prev_col_ff;
      x              = in_frame_start_ff ? '0 : col_ff;
      eff_row        = in_frame_start_ff ? '0 : row_ff;
      good           = (in_mask_ff & bad_mask_ff) == '0;
      above          = in_value_ff > threshold_ff;
      higher         = in_value_ff > eff_prev_value;
      lower          = in_value_ff < eff_prev_value;
   end

   // next state
   always_comb begin
      mid_mode  = eff_mode;
      mid_start = open_start_ff;
      mid_peak  = open_peak_ff;
      if (good) begin
         unique case (eff_mode)
            MODE_RISING: begin
               if (!above) begin
                  mid_mode = MODE_IDLE;
               end else if (lower) begin
                  mid_mode = MODE_FALLING;
                  mid_peak = eff_prev_col;
               end
            end
            MODE_FALLING: begin
               if (!above) begin
                  mid_mode = MODE_IDLE;
               end else if (higher) begin
                  mid_mode  = MODE_RISING;
                  mid_start = x;
               end
            end
            default: begin
               mid_mode = MODE_IDLE;
               if (above) begin
                  mid_mode  = MODE_RISING;
                  mid_start = x;
               end
            end
         endcase
      end

      open_start_in = mid_start;
      open_peak_in  = mid_peak;
      if (in_row_end_ff) begin
         mode_in       = MODE_IDLE;
         prev_value_in = '0;
         prev_col_in   = '0;
         col_in        = '0;
         row_in        = (eff_row != ROW_MAX) ? eff_row + 1'b1 : eff_row;
      end else begin
         mode_in       = mid_mode;
         prev_value_in = good ? in_value_ff : eff_prev_value;
         prev_col_in   = good ? x : eff_prev_col;
         col_in        = (x != COL_MAX) ? x + 1'b1 : x;
         row_in        = eff_row;
      end
   end

   // span items
   always_comb begin
      ea_v           = 1'b0;
      ea.row_index   = to_row(eff_row);
      ea.span_start  = to_span(open_start_ff);
      ea.peak_column = to_span(open_peak_ff);
      ea.span_end    = to_span(eff_prev_col);
      ea.last_of_run = 1'b0;
      if (good) begin
         unique case (eff_mode)
            MODE_RISING: begin
               if (!above) begin
                  ea_v           = 1'b1;
                  ea.peak_column = to_span(eff_prev_col);
               end
            end
            MODE_FALLING: begin
               ea_v = !above || higher;
            end
            default: ;
         endcase
      end

      eb_v           = 1'b0;
      eb.row_index   = to_row(eff_row);
      eb.span_start  = to_span(mid_start);
      eb.peak_column = to_span(mid_peak);
      eb.span_end    = to_span(x);
      eb.last_of_run = 1'b1;
      if (in_row_end_ff) begin
         unique case (mid_mode)
            MODE_RISING: begin
               eb_v           = 1'b1;
               eb.peak_column = to_span(x);
            end
            MODE_FALLING: eb_v = 1'b1;
            default: ;
         endcase
      end
      ea.last_of_run = !eb_v;

      push.first_valid  = take && (ea_v || eb_v);
      push.second_valid = take && ea_v && eb_v;
      push.first        = ea_v ? ea : eb;
      push.second       = eb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         open_start_ff <= '0;
         open_peak_ff  <= '0;
         prev_value_ff <= '0;
         prev_col_ff   <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
      end else if (take) begin
         mode_ff       <= mode_in;
         open_start_ff <= open_start_in;
         open_peak_ff  <= open_peak_in;
         prev_value_ff <= prev_value_in;
         prev_col_ff   <= prev_col_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
      end
   end

   a_row_end_clears: assert property (@(posedge clock) disable iff (reset)
      take && in_row_end_ff |=> col_ff == '0 && mode_ff == MODE_IDLE)
      else $error("row end did not clear the column state");

   a_frame_start_row: assert property (@(posedge clock) disable iff (reset)
      take && in_frame_start_ff && !in_row_end_ff |=> row_ff == '0)
      else $error("frame start did not clear the row count");

   a_second_needs_row_end: assert property (@(posedge clock) disable iff (reset)
      push.second_valid |-> in_row_end_ff && push.first_valid)
      else $error("second item without a row end flush");

endmodule

`default_nettype wire

@@ rtl/rtpf_out_queue.sv @@
// rtpf_out_queue: four-entry queue of span items in front of the result channel
// takes up to two items per cycle; depends on rtpf_pkg and rtpf_rsp_if
`timescale 1ns / 1ps
`default_nettype none

module rtpf_out_queue
   import rtpf_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  push_type  push,
   output logic      space_ok,
   rtpf_rsp_if.source rsp
);

   result_type        mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              pop;
   logic [1:0]        n_push;
   result_type        head;

   assign head            = mem[rd_ptr_ff];
   assign rsp.valid       = count_ff != '0;
   assign rsp.row_index   = head.row_index;
   assign rsp.span_start  = head.span_start;
   assign rsp.peak_column = head.peak_column;
   assign rsp.span_end    = head.span_end;
   assign rsp.last_of_run = head.last_of_run;

   assign pop      = rsp.valid && rsp.ready;
   assign space_ok = count_ff <= QCNT_W'(QUEUE_DEPTH - 2);
   assign n_push   = {1'b0, push.first_valid} + {1'b0, push.second_valid};

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(n_push);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + QCNT_W'(n_push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.second_valid) begin
         mem[wr_ptr_ff + 1'b1] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("span queue overfilled");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push.first_valid |-> space_ok)
      else $error("item pushed without room");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      QPTR_W'(wr_ptr_ff - rd_ptr_ff) == count_ff[QPTR_W-1:0])
      else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire
